>>> hw/rtl/itp_pkg.sv
package itp_pkg;

	// result kinds
	localparam logic [2:0] KIND_CHAR       = 3'd0;
	localparam logic [2:0] KIND_OK         = 3'd1;
	localparam logic [2:0] KIND_INVALID    = 3'd2;
	localparam logic [2:0] KIND_UNBALANCED = 3'd3;
	localparam logic [2:0] KIND_OVERFLOW   = 3'd4;
	localparam logic [2:0] KIND_NONE       = 3'd0;

	// special characters
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] symbol;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic [2:0] kind;
		logic       last;
	} out_req_t;

	// operator priority, zero for anything that is not an operator
	function automatic logic [1:0] op_rank(input logic [7:0] c);
		logic [1:0] r;
		r = 2'd0;
		if (c == CH_CARET) begin
			r = 2'd3;
		end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
			r = 2'd2;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			r = 2'd1;
		end
		return r;
	endfunction

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

>>> hw/rtl/itp_ram.sv
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/infix_to_postfix_converter_top.sv
// Infix to postfix converter (shunting yard), one character per request.
//
// Input channel (in_valid/in_ready/in_req): one request is either an
// expression character (action = 0) or the end marker (action = 1).
// Output channel (out_valid/out_ready/out_req): postfix characters
// (kind = 0) and, for an end marker, one status request (kind 1..4).
// last marks the final output request caused by one input request.
//
// Flow: an input request passes the states S_IDLE, S_EXEC and S_FIN, and
// S_EXEC pops the operators off the stack one at a time. The pop loop is one
// read of the stack RAM per cycle while the output is not stalled. The input
// is taken again while the last output still sits in the output register.
// The newest output is held one step in a pending register so that last can
// be set once the pop loop knows it has stopped.
//
// When the receiver stalls, the output register holds and the pop loop
// waits; nothing is dropped. Reset clears the stack count, the paren count,
// the sticky error and all valid flags; the stack RAM needs no clearing.
// After an error, characters are swallowed until the end marker reports it.
module infix_to_postfix_converter_top
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_req,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_req
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic          act_q;
	logic [7:0]    sym_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] paren_q;
	logic [2:0]    err_q;

	// output register and the pending request behind it
	out_req_t   o_q;
	logic       o_valid_q;
	logic [7:0] p_sym_q;
	logic [2:0] p_kind_q;
	logic       p_valid_q;

	logic [7:0]    top;
	logic [AW-1:0] rd_addr;
	logic          top_valid;
	logic          o_free;
	logic          want_pop;
	logic          pop_now;
	logic          push_req;
	logic          push_now;
	logic          emit_now;
	logic          full;
	logic [1:0]    sym_r;
	logic [1:0]    top_r;
	logic [2:0]    status;
	logic [CW-1:0] rd_sel;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = o_valid_q;
	assign out_req   = o_q;

	assign top_valid = (sp_q != '0);
	assign full      = (sp_q >= CW'(STACK_DEPTH));
	assign o_free    = !o_valid_q || out_ready;
	assign sym_r     = op_rank(sym_q);
	assign top_r     = op_rank(top);

	always_comb begin
		want_pop = 1'b0;
		if (act_q == ACT_END) begin
			want_pop = (err_q == KIND_NONE) && (paren_q == '0) && top_valid;
		end else if (err_q == KIND_NONE) begin
			if (sym_q == CH_RPAREN) begin
				want_pop = top_valid && (top != CH_LPAREN);
			end else if (sym_r != 2'd0) begin
				want_pop = top_valid && (top_r != 2'd0) &&
					((top_r > sym_r) || (top_r == sym_r && sym_q != CH_CARET));
			end
		end
	end

	assign push_req = (act_q == ACT_CHAR) && (err_q == KIND_NONE) && !want_pop &&
		((sym_q == CH_LPAREN) || (sym_r != 2'd0));
	assign push_now = (state_q == S_EXEC) && push_req && !full;
	assign pop_now  = (state_q == S_EXEC) && want_pop && o_free;

	// cycles in which a new request moves into the pending register
	assign emit_now = (state_q == S_EXEC) && o_free &&
		(want_pop || (act_q == ACT_END) || ((err_q == KIND_NONE) && is_operand(sym_q)));

	// read the new top right behind a pop so it is ready next cycle
	assign rd_sel  = pop_now ? (sp_q - CW'(2)) : (sp_q - CW'(1));
	assign rd_addr = rd_sel[AW-1:0];

	always_comb begin
		if (err_q != KIND_NONE) begin
			status = err_q;
		end else if (paren_q != '0) begin
			status = KIND_UNBALANCED;
		end else begin
			status = KIND_OK;
		end
	end

	itp_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (push_now),
		.waddr(sp_q[AW-1:0]),
		.wdata(sym_q),
		.raddr(rd_addr),
		.rdata(top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			paren_q   <= '0;
			err_q     <= KIND_NONE;
			o_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
			p_kind_q  <= KIND_CHAR;
		end else begin
			if (out_ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (want_pop) begin
						if (o_free) begin
							o_valid_q <= p_valid_q;
							p_valid_q <= 1'b1;
							p_kind_q  <= KIND_CHAR;
							sp_q      <= sp_q - CW'(1);
						end
					end else if (act_q == ACT_END) begin
						if (o_free) begin
							o_valid_q <= p_valid_q;
							p_valid_q <= 1'b1;
							p_kind_q  <= status;
							sp_q      <= '0;
							paren_q   <= '0;
							err_q     <= KIND_NONE;
							state_q   <= S_FIN;
						end
					end else if (err_q != KIND_NONE) begin
						state_q <= S_FIN;
					end else if (is_operand(sym_q)) begin
						if (o_free) begin
							o_valid_q <= p_valid_q;
							p_valid_q <= 1'b1;
							p_kind_q  <= KIND_CHAR;
							state_q   <= S_FIN;
						end
					end else if (sym_q == CH_RPAREN) begin
						if (top_valid) begin
							sp_q <= sp_q - CW'(1);
							if (paren_q != '0) begin
								paren_q <= paren_q - CW'(1);
							end
						end else begin
							err_q <= KIND_UNBALANCED;
						end
						state_q <= S_FIN;
					end else if (push_req) begin
						if (full) begin
							err_q <= KIND_OVERFLOW;
						end else begin
							sp_q <= sp_q + CW'(1);
							if (sym_q == CH_LPAREN) begin
								paren_q <= paren_q + CW'(1);
							end
						end
						state_q <= S_FIN;
					end else begin
						err_q   <= KIND_INVALID;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (p_valid_q) begin
						if (o_free) begin
							o_valid_q <= 1'b1;
							p_valid_q <= 1'b0;
							state_q   <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= in_req.action;
			sym_q <= in_req.symbol;
		end
		case (state_q)
			S_EXEC: begin
				if (emit_now) begin
					o_q.out_symbol <= p_sym_q;
					o_q.kind       <= p_kind_q;
					o_q.last       <= 1'b0;
					if (want_pop) begin
						p_sym_q <= top;
					end else if (act_q == ACT_END) begin
						p_sym_q <= 8'd0;
					end else begin
						p_sym_q <= sym_q;
					end
				end
			end
			S_FIN: begin
				if (o_free && p_valid_q) begin
					o_q.out_symbol <= p_sym_q;
					o_q.kind       <= p_kind_q;
					o_q.last       <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
